[rtl/smft_pkg.sv]
package smft_pkg;

    localparam int MAX_DIM    = 16;
    localparam int MAX_TERMS  = 32;
    localparam int VALUE_BITS = 16;

    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int CFG_W      = 5;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int TERM_IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);
    localparam int ENTRY_W    = ROW_W + COL_W + VALUE_BITS;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // tuser bit positions on the result side
    localparam int TU_HDR = 0;
    localparam int TU_ERR = 1;

    // configuration register indexes
    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DECIDE,
        S_HDR,
        S_PREFIX,
        S_SCATTER,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef struct packed {
        logic load_term;
        logic clr_matrix;
        logic pfx_clr;
        logic pfx_step;
        logic idx_clr;
        logic sc_issue;
        logic em_rd;
        logic ld_hdr;
        logic ld_term;
    } cmd_t;

    typedef struct packed {
        logic hdr_only;
        logic pfx_done;
        logic sc_done;
        logic em_last;
        logic out_free;
    } status_t;

endpackage

[rtl/smft_ctrl.sv]
module smft_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    input  smft_pkg::status_t status,
    output smft_pkg::cmd_t    cmd
);

    smft_pkg::state_t state_reg;
    smft_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smft_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smft_pkg::S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = smft_pkg::S_DECIDE;
                end
            end
            smft_pkg::S_DECIDE:
            begin
                state_next = smft_pkg::S_HDR;
            end
            smft_pkg::S_HDR:
            begin
                if (status.out_free)
                begin
                    state_next = status.hdr_only ? smft_pkg::S_LOAD : smft_pkg::S_PREFIX;
                end
            end
            smft_pkg::S_PREFIX:
            begin
                if (status.pfx_done)
                begin
                    state_next = smft_pkg::S_SCATTER;
                end
            end
            smft_pkg::S_SCATTER:
            begin
                if (status.sc_done)
                begin
                    state_next = smft_pkg::S_EMIT_RD;
                end
            end
            smft_pkg::S_EMIT_RD:
            begin
                if (status.out_free)
                begin
                    state_next = smft_pkg::S_EMIT_LD;
                end
            end
            smft_pkg::S_EMIT_LD:
            begin
                state_next = status.em_last ? smft_pkg::S_LOAD : smft_pkg::S_EMIT_RD;
            end
            default:
            begin
                state_next = smft_pkg::S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            smft_pkg::S_LOAD:
            begin
                in_ready      = 1'b1;
                cmd.load_term = in_valid;
            end
            smft_pkg::S_DECIDE:
            begin
                cmd.pfx_clr = 1'b1;
                cmd.idx_clr = 1'b1;
            end
            smft_pkg::S_HDR:
            begin
                cmd.ld_hdr     = status.out_free;
                cmd.clr_matrix = status.out_free && status.hdr_only;
            end
            smft_pkg::S_PREFIX:
            begin
                cmd.pfx_step = 1'b1;
            end
            smft_pkg::S_SCATTER:
            begin
                cmd.sc_issue = !status.sc_done;
                cmd.idx_clr  = status.sc_done;
            end
            smft_pkg::S_EMIT_RD:
            begin
                cmd.em_rd = status.out_free;
            end
            smft_pkg::S_EMIT_LD:
            begin
                cmd.ld_term    = 1'b1;
                cmd.clr_matrix = status.em_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/smft_datapath.sv]
module smft_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  smft_pkg::cmd_t                     cmd,
    output smft_pkg::status_t                  status,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [smft_pkg::CFG_W-1:0]         cfg_data,
    input  logic [smft_pkg::ROW_W-1:0]         in_row,
    input  logic [smft_pkg::COL_W-1:0]         in_col,
    input  logic [smft_pkg::VALUE_BITS-1:0]    in_value,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [smft_pkg::CFG_W-1:0]         out_row,
    output logic [smft_pkg::CFG_W-1:0]         out_col,
    output logic [smft_pkg::VALUE_BITS-1:0]    out_value,
    output logic                               out_hdr,
    output logic                               out_last,
    output logic                               out_err
);

    localparam int RW = smft_pkg::ROW_W;
    localparam int CW = smft_pkg::COL_W;
    localparam int VW = smft_pkg::VALUE_BITS;
    localparam int NW = smft_pkg::CNT_W;

    logic [smft_pkg::CFG_W-1:0] num_rows_reg;
    logic [smft_pkg::CFG_W-1:0] num_cols_reg;
    logic [NW-1:0]              cnt_reg;
    logic                       err_reg;
    logic [NW-1:0]              col_cnt_reg [smft_pkg::MAX_DIM];
    logic [NW-1:0]              start_reg   [smft_pkg::MAX_DIM];
    logic [smft_pkg::DIM_W-1:0] pfx_reg;
    logic [NW-1:0]              run_reg;
    logic [NW-1:0]              idx_reg;
    logic                       sc_vld_reg;

    logic [smft_pkg::ENTRY_W-1:0] term_mem [smft_pkg::MAX_TERMS];
    logic [smft_pkg::ENTRY_W-1:0] tp_mem   [smft_pkg::MAX_TERMS];
    logic [smft_pkg::ENTRY_W-1:0] term_rd_reg;
    logic [smft_pkg::ENTRY_W-1:0] tp_rd_reg;

    logic                       out_valid_reg;
    logic [smft_pkg::CFG_W-1:0] out_row_reg;
    logic [smft_pkg::CFG_W-1:0] out_col_reg;
    logic [VW-1:0]              out_val_reg;
    logic                       out_hdr_reg;
    logic                       out_last_reg;
    logic                       out_err_reg;

    logic          term_ok;
    logic          store_term;
    logic [NW-1:0] idx_inc;
    logic [CW-1:0] sc_col;
    logic [NW-1:0] sc_pos;

    // stored entry layout: {row, col, value}; transposed entry: {new row, new col, value}
    assign term_ok    = (smft_pkg::CFG_W'(in_col) < num_cols_reg)
                        && (cnt_reg < NW'(smft_pkg::MAX_TERMS));
    assign store_term = cmd.load_term && term_ok;
    assign idx_inc    = idx_reg + NW'(1);
    assign sc_col     = term_rd_reg[VW +: CW];
    assign sc_pos     = start_reg[sc_col];

    assign status.hdr_only = err_reg || (cnt_reg == '0);
    assign status.pfx_done = (pfx_reg == smft_pkg::DIM_W'(smft_pkg::MAX_DIM - 1));
    assign status.sc_done  = (idx_reg == cnt_reg);
    assign status.em_last  = (idx_inc == cnt_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= smft_pkg::CFG_W'(smft_pkg::MAX_DIM);
            num_cols_reg <= smft_pkg::CFG_W'(smft_pkg::MAX_DIM);
        end
        else if (cfg_we)
        begin
            if (cfg_index == smft_pkg::CFG_NUM_ROWS)
            begin
                num_rows_reg <= cfg_data;
            end
            else
            begin
                num_cols_reg <= cfg_data;
            end
        end
    end

    // per-matrix control: term count, error flag and column histogram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
            for (int i = 0; i < smft_pkg::MAX_DIM; i++)
            begin
                col_cnt_reg[i] <= '0;
            end
        end
        else if (cmd.clr_matrix)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
            for (int i = 0; i < smft_pkg::MAX_DIM; i++)
            begin
                col_cnt_reg[i] <= '0;
            end
        end
        else if (cmd.load_term)
        begin
            if (term_ok)
            begin
                cnt_reg             <= cnt_reg + NW'(1);
                col_cnt_reg[in_col] <= col_cnt_reg[in_col] + NW'(1);
            end
            else
            begin
                err_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfx_reg    <= '0;
            run_reg    <= '0;
            idx_reg    <= '0;
            sc_vld_reg <= 1'b0;
        end
        else
        begin
            sc_vld_reg <= cmd.sc_issue;
            if (cmd.pfx_clr)
            begin
                pfx_reg <= '0;
                run_reg <= '0;
            end
            else if (cmd.pfx_step)
            begin
                pfx_reg <= pfx_reg + smft_pkg::DIM_W'(1);
                run_reg <= run_reg + col_cnt_reg[pfx_reg];
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.sc_issue || cmd.ld_term)
            begin
                idx_reg <= idx_inc;
            end
        end
    end

    // start positions: written by the prefix pass, bumped by each scattered term
    always_ff @(posedge clk)
    begin
        if (cmd.pfx_step)
        begin
            start_reg[pfx_reg] <= run_reg;
        end
        else if (sc_vld_reg)
        begin
            start_reg[sc_col] <= sc_pos + NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_term)
        begin
            term_mem[cnt_reg[smft_pkg::TERM_IDX_W-1:0]] <= {in_row, in_col, in_value};
        end
        if (cmd.sc_issue)
        begin
            term_rd_reg <= term_mem[idx_reg[smft_pkg::TERM_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_vld_reg)
        begin
            tp_mem[sc_pos[smft_pkg::TERM_IDX_W-1:0]] <=
                {sc_col, term_rd_reg[VW + CW +: RW], term_rd_reg[VW-1:0]};
        end
        if (cmd.em_rd)
        begin
            tp_rd_reg <= tp_mem[idx_reg[smft_pkg::TERM_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_hdr || cmd.ld_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_hdr)
        begin
            out_row_reg  <= num_cols_reg;
            out_col_reg  <= num_rows_reg;
            out_val_reg  <= VW'(cnt_reg);
            out_hdr_reg  <= 1'b1;
            out_last_reg <= status.hdr_only;
            out_err_reg  <= err_reg;
        end
        else if (cmd.ld_term)
        begin
            out_row_reg  <= smft_pkg::CFG_W'(tp_rd_reg[VW + RW +: CW]);
            out_col_reg  <= smft_pkg::CFG_W'(tp_rd_reg[VW +: RW]);
            out_val_reg  <= tp_rd_reg[VW-1:0];
            out_hdr_reg  <= 1'b0;
            out_last_reg <= status.em_last;
            out_err_reg  <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_val_reg;
    assign out_hdr   = out_hdr_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

endmodule

[rtl/sparse_matrix_fast_transpose.sv]
// Channel   Dir  Transfer when              Contents
// s_axis    in   s_axis_tvalid & tready     one source term; tlast marks the final term
// m_axis    out  m_axis_tvalid & tready     header, then transposed terms; tlast on final
// cfg       in   cfg_valid & cfg_ready      index 0: num_rows, index 1: num_cols
//
// Terms load at one per cycle. After the final term: a decide state, the header, a
// prefix pass over the column counts, a scatter of the n terms (one read of the term
// memory per cycle), then for each emitted term a read of the transposed memory
// and a load of the output register. Error or empty: header only.
// Reset clears control state; memories need no clearing pass.
// A stalled output holds its register; input is not taken until the run is done.
module sparse_matrix_fast_transpose
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] term_row, [7:4] term_col, [23:8] term_value
    input  logic [smft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [4:0] out_row, [9:5] out_col, [25:10] out_value, [31:26] zero
    output logic [smft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] is_header, [1] error
    output logic [smft_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [smft_pkg::CFG_W-1:0]          cfg_data
);

    smft_pkg::cmd_t    cmd;
    smft_pkg::status_t status;

    logic [smft_pkg::CFG_W-1:0]      out_row;
    logic [smft_pkg::CFG_W-1:0]      out_col;
    logic [smft_pkg::VALUE_BITS-1:0] out_value;
    logic                            out_hdr;
    logic                            out_err;

    assign cfg_ready = 1'b1;

    smft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smft_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_row    (s_axis_tdata[3:0]),
        .in_col    (s_axis_tdata[7:4]),
        .in_value  (s_axis_tdata[23:8]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_hdr   (out_hdr),
        .out_last  (m_axis_tlast),
        .out_err   (out_err)
    );

    assign m_axis_tdata = {6'b0, out_value, out_col, out_row};
    assign m_axis_tuser = {out_err, out_hdr};

    // an error header always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[smft_pkg::TU_ERR]
        |-> m_axis_tuser[smft_pkg::TU_HDR] && m_axis_tlast)
        else $error("error result is not a closing header");

    // no further term is taken straight after the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during transpose");

    // a header followed by terms carries a non-zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[smft_pkg::TU_HDR] && !m_axis_tlast
        |-> m_axis_tdata[25:10] != '0)
        else $error("open header with zero count");

    // the output register is only reloaded when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_hdr || cmd.ld_term |-> !m_axis_tvalid || m_axis_tready)
        else $error("output register overwritten");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        last;
    } term_t;

    typedef struct packed {
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] value;
        logic        hdr;
        logic        last;
        logic        err;
    } tpose_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [smft_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [smft_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [smft_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_index = smft_pkg::CFG_NUM_ROWS;
    logic [smft_pkg::CFG_W-1:0]       cfg_data = '0;

    sparse_matrix_fast_transpose u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    term_t  term_q[$];
    tpose_t tpose_q[$];
    term_t  term_on_bus;

    // predictor state
    logic [4:0]  dim_rows = 5'd16;
    logic [4:0]  dim_cols = 5'd16;
    logic [3:0]  held_row[smft_pkg::MAX_TERMS];
    logic [3:0]  held_col[smft_pkg::MAX_TERMS];
    logic [15:0] held_val[smft_pkg::MAX_TERMS];
    int          held_n   = 0;
    logic        held_err = 1'b0;

    int idle_pct     = 8;
    int fail_count   = 0;
    int terms_queued = 0;
    int terms_taken  = 0;
    int matrices     = 0;
    int err_headers  = 0;
    int results_seen = 0;

    task automatic transpose_term(input term_t t);
        int     counts[smft_pkg::MAX_DIM];
        int     starts[smft_pkg::MAX_DIM];
        tpose_t slot[smft_pkg::MAX_TERMS];
        tpose_t r;
        int     j;
        if (t.col >= dim_cols)
            held_err = 1'b1;
        else if (held_n >= smft_pkg::MAX_TERMS)
            held_err = 1'b1;
        else
        begin
            held_row[held_n] = t.row;
            held_col[held_n] = t.col;
            held_val[held_n] = t.value;
            held_n++;
        end
        if (t.last)
        begin
            matrices++;
            r.row   = dim_cols;
            r.col   = dim_rows;
            r.value = 16'(held_n);
            r.hdr   = 1'b1;
            if (held_err || held_n == 0)
            begin
                r.last = 1'b1;
                r.err  = held_err;
                if (held_err)
                    err_headers++;
                tpose_q.push_back(r);
            end
            else
            begin
                r.last = 1'b0;
                r.err  = 1'b0;
                tpose_q.push_back(r);
                for (int c = 0; c < smft_pkg::MAX_DIM; c++)
                    counts[c] = 0;
                for (int i = 0; i < held_n; i++)
                    counts[held_col[i]]++;
                starts[0] = 0;
                for (int c = 1; c < smft_pkg::MAX_DIM; c++)
                    starts[c] = starts[c-1] + counts[c-1];
                for (int i = 0; i < held_n; i++)
                begin
                    j = starts[held_col[i]];
                    starts[held_col[i]] = j + 1;
                    slot[j].row   = {1'b0, held_col[i]};
                    slot[j].col   = {1'b0, held_row[i]};
                    slot[j].value = held_val[i];
                    slot[j].hdr   = 1'b0;
                    slot[j].last  = (j == held_n - 1);
                    slot[j].err   = 1'b0;
                end
                for (int i = 0; i < held_n; i++)
                    tpose_q.push_back(slot[i]);
            end
            held_n   = 0;
            held_err = 1'b0;
        end
    endtask

    // driver: source terms
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                transpose_term(term_on_bus);
                terms_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (term_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    term_on_bus = term_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {term_on_bus.value, term_on_bus.col, term_on_bus.row};
                    s_axis_tlast  <= term_on_bus.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // monitor: transposed results
    always @(posedge clk or negedge rst_n)
    begin
        tpose_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (tpose_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: tdata %0h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = tpose_q.pop_front();
                    cmp_field("out_row",   16'(want.row),  16'(m_axis_tdata[4:0]));
                    cmp_field("out_col",   16'(want.col),  16'(m_axis_tdata[9:5]));
                    cmp_field("out_value", want.value,     m_axis_tdata[25:10]);
                    cmp_field("is_header", 16'(want.hdr),
                              16'(m_axis_tuser[smft_pkg::TU_HDR]));
                    cmp_field("out_last",  16'(want.last), 16'(m_axis_tlast));
                    cmp_field("error",     16'(want.err),
                              16'(m_axis_tuser[smft_pkg::TU_ERR]));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic add_term(input int row, input int col, input int value, input bit last);
        term_t t;
        t.row   = 4'(row);
        t.col   = 4'(col);
        t.value = 16'(value);
        t.last  = last;
        term_q.push_back(t);
        terms_queued++;
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == smft_pkg::CFG_NUM_ROWS)
            dim_rows = val;
        else
            dim_cols = val;
        cfg_valid <= 1'b0;
    endtask

    // all terms taken and every result in, then a margin for the block to settle
    task automatic wait_drained();
        while (terms_taken != terms_queued || tpose_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 1;
        else if (r < 30)
            return 16;
        else
            return $urandom_range(1, 16);
    endfunction

    // one matrix of n terms; bad puts one column at or above num_cols
    task automatic gen_matrix(input int n, input bit bad);
        int bad_at;
        int col;
        bad_at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (bad && i == bad_at)
                col = $urandom_range(dim_cols, 15);
            else
                col = $urandom_range(0, dim_cols - 1);
            add_term($urandom_range(0, 15), col, $urandom_range(0, 65535), i == n - 1);
        end
    endtask

    initial
    begin
        int random_terms;
        int sz;
        int r;
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset dimensions 16 x 16: extremes, shared columns, single term
        add_term(0,  0,  16'h7FFF, 0);
        add_term(15, 15, 16'h8000, 0);
        add_term(5,  3,  16'hFFFF, 0);
        add_term(10, 3,  16'h0000, 0);
        add_term(3,  0,  16'h5555, 1);
        add_term(15, 15, 16'hAAAA, 1);
        wait_drained();

        // 1 x 1: rows carried unchecked, column out of range, rejected last term
        write_reg(smft_pkg::CFG_NUM_ROWS, 5'd1);
        write_reg(smft_pkg::CFG_NUM_COLS, 5'd1);
        add_term(0,  0,  16'h0001, 0);
        add_term(15, 0,  16'hFFFE, 1);
        add_term(0,  0,  16'h1234, 0);
        add_term(3,  5,  16'h4321, 0);
        add_term(2,  0,  16'h00FF, 1);
        add_term(7,  7,  16'hFF00, 1);
        add_term(1,  15, 16'h8001, 1);
        wait_drained();

        write_reg(smft_pkg::CFG_NUM_COLS, 5'd16);
        write_reg(smft_pkg::CFG_NUM_ROWS, 5'd16);

        random_terms = 0;
        phase = 0;
        while (random_terms < 210)
        begin
            wait_drained();
            idle_pct = (phase == 2) ? 0 : 8;
            if (phase > 0)
            begin
                write_reg(smft_pkg::CFG_NUM_ROWS, 5'(pick_dim()));
                write_reg(smft_pkg::CFG_NUM_COLS, 5'(pick_dim()));
            end
            for (int m = 0; m < 3; m++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    sz = smft_pkg::MAX_TERMS;
                else if (r < 10)
                    sz = $urandom_range(smft_pkg::MAX_TERMS + 1, smft_pkg::MAX_TERMS + 4);
                else
                    sz = $urandom_range(1, 8);
                gen_matrix(sz, (dim_cols < 16) && ($urandom_range(0, 99) < 12));
                random_terms += sz;
            end
            phase++;
        end
        wait_drained();
        idle_pct = 8;
        repeat (20) @(posedge clk);

        $display("Covered %0d matrices from %0d terms over %0d settings, %0d results checked,",
                 matrices, terms_taken, phase + 2, results_seen);
        $display("%0d of them headers flagged with an error.", err_headers);
        if (fail_count == 0 && tpose_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
